// ----- src/adts_frame_splitter_core_macros.svh -----
// Assertion macros used by the ADTS frame splitter core.
`ifndef ADTS_FRAME_SPLITTER_CORE_MACROS_SVH
`define ADTS_FRAME_SPLITTER_CORE_MACROS_SVH

// Implication checked on the same clock edge.
`define ADTS_FS_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("adts frame splitter check failed");

// Implication checked on the next clock edge.
`define ADTS_FS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("adts frame splitter check failed");

`endif

// ----- src/adts_fs_pkg.sv -----
// Package of types, codes and the sample rate table of the ADTS frame splitter.
`timescale 1ns / 1ps
package adts_fs_pkg;

  localparam logic [1:0] PH_HUNT    = 2'd0;
  localparam logic [1:0] PH_SYNC2   = 2'd1;
  localparam logic [1:0] PH_HEADER  = 2'd2;
  localparam logic [1:0] PH_PAYLOAD = 2'd3;

  localparam logic [7:0]  SYNC_BYTE   = 8'hFF;
  localparam logic [3:0]  SYNC_NIBBLE = 4'hF;
  localparam logic [2:0]  HDR_LAST    = 3'd7;
  localparam logic [12:0] HDR_BYTES   = 13'd7;

  typedef struct packed {
    logic [7:0]  payload_byte;
    logic        last_byte;
    logic        frame_error;
    logic        mpeg_id;
    logic        crc_absent;
    logic [1:0]  profile;
    logic [3:0]  freq_index;
    logic [16:0] sample_rate;
    logic [2:0]  channel_config;
    logic [12:0] frame_length;
  } result_t;

  typedef struct packed {
    logic [1:0] phase;
  } parser_status_t;

  function automatic logic [16:0] rate_of(input logic [3:0] idx);
    logic [16:0] r;
    case (idx)
      4'd0:    r = 17'd96000;
      4'd1:    r = 17'd88200;
      4'd2:    r = 17'd64000;
      4'd3:    r = 17'd48000;
      4'd4:    r = 17'd44100;
      4'd5:    r = 17'd32000;
      4'd6:    r = 17'd24000;
      4'd7:    r = 17'd22050;
      4'd8:    r = 17'd16000;
      4'd9:    r = 17'd12000;
      4'd10:   r = 17'd11025;
      4'd11:   r = 17'd8000;
      4'd12:   r = 17'd7350;
      default: r = 17'd0;
    endcase
    return r;
  endfunction

endpackage

// ----- src/adts_fs_if.sv -----
// Stream interfaces of the ADTS frame splitter: byte input and result output.
`timescale 1ns / 1ps
interface adts_fs_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] stream_byte;

  modport source (output valid, output stream_byte, input ready);
  modport sink (input valid, input stream_byte, output ready);
endinterface

interface adts_fs_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  payload_byte;
  logic        last_byte;
  logic        frame_error;
  logic        mpeg_id;
  logic        crc_absent;
  logic [1:0]  profile;
  logic [3:0]  freq_index;
  logic [16:0] sample_rate;
  logic [2:0]  channel_config;
  logic [12:0] frame_length;

  modport source (output valid, output payload_byte, output last_byte, output frame_error,
                  output mpeg_id, output crc_absent, output profile, output freq_index,
                  output sample_rate, output channel_config, output frame_length,
                  input ready);
  modport sink (input valid, input payload_byte, input last_byte, input frame_error,
                input mpeg_id, input crc_absent, input profile, input freq_index,
                input sample_rate, input channel_config, input frame_length,
                output ready);
endinterface

// ----- src/adts_fs_parser.sv -----
// Per-byte sync hunt, header collection and payload count of the ADTS stream.
`timescale 1ns / 1ps
module adts_fs_parser (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        accept_i,
  input  logic [7:0]                  byte_i,
  output logic                        res_valid_o,
  output adts_fs_pkg::result_t        result_o,
  output adts_fs_pkg::parser_status_t status_o
);
  import adts_fs_pkg::*;

  logic [1:0]  phase_q, phase_d;
  logic [2:0]  cnt_q, cnt_d;
  logic [55:0] hdr_q, hdr_d;
  logic [12:0] left_q, left_d;
  logic [12:0] len;
  logic        last;
  logic        res_err;

  assign len  = hdr_d[25:13];
  assign last = (left_q <= 13'd1);

  always_comb begin
    phase_d     = phase_q;
    cnt_d       = cnt_q;
    hdr_d       = hdr_q;
    left_d      = left_q;
    res_valid_o = 1'b0;
    res_err     = 1'b0;
    case (phase_q)
      PH_HUNT: begin
        if (byte_i == SYNC_BYTE) begin
          hdr_d   = {48'd0, SYNC_BYTE};
          cnt_d   = 3'd1;
          phase_d = PH_SYNC2;
        end
      end
      PH_SYNC2: begin
        if (byte_i[7:4] == SYNC_NIBBLE) begin
          hdr_d   = {hdr_q[47:0], byte_i};
          cnt_d   = 3'd2;
          phase_d = PH_HEADER;
        end else begin
          cnt_d   = 3'd0;
          phase_d = PH_HUNT;
        end
      end
      PH_HEADER: begin
        hdr_d = {hdr_q[47:0], byte_i};
        cnt_d = cnt_q + 3'd1;
        if (cnt_d == HDR_LAST) begin
          cnt_d = 3'd0;
          if (len <= HDR_BYTES) begin
            phase_d     = PH_HUNT;
            left_d      = 13'd0;
            res_valid_o = 1'b1;
            res_err     = 1'b1;
          end else begin
            left_d  = len - HDR_BYTES;
            phase_d = PH_PAYLOAD;
          end
        end
      end
      default: begin
        res_valid_o = 1'b1;
        if (last) begin
          left_d  = 13'd0;
          phase_d = PH_HUNT;
        end else begin
          left_d = left_q - 13'd1;
        end
      end
    endcase
  end

  // Fields come from the header as it stands after this byte, which matters
  // only for the error result on the last header byte.
  always_comb begin
    result_o.payload_byte   = res_err ? 8'd0 : byte_i;
    result_o.last_byte      = !res_err && last;
    result_o.frame_error    = res_err;
    result_o.mpeg_id        = hdr_d[43];
    result_o.crc_absent     = hdr_d[40];
    result_o.profile        = hdr_d[39:38];
    result_o.freq_index     = hdr_d[37:34];
    result_o.sample_rate    = rate_of(hdr_d[37:34]);
    result_o.channel_config = hdr_d[32:30];
    result_o.frame_length   = hdr_d[25:13];
  end

  assign status_o.phase = phase_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HUNT;
      cnt_q   <= 3'd0;
      hdr_q   <= 56'd0;
      left_q  <= 13'd0;
    end else if (accept_i) begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      hdr_q   <= hdr_d;
      left_q  <= left_d;
    end
  end

endmodule

// ----- src/adts_fs_out_reg.sv -----
// Result register that decouples the parser from a stalling result sink.
`timescale 1ns / 1ps
module adts_fs_out_reg (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 load_i,
  input  logic                 res_valid_i,
  input  adts_fs_pkg::result_t result_i,
  output logic                 can_load_o,
  adts_fs_out_if.source        result_o
);
  import adts_fs_pkg::*;

  logic    valid_q, valid_d;
  result_t data_q;

  // A new beat may enter whenever the register is empty or the held one leaves in the same cycle.
  assign can_load_o = !valid_q || result_o.ready;

  always_comb begin
    valid_d = valid_q && !result_o.ready;
    if (load_i) begin
      valid_d = res_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i && res_valid_i) begin
      data_q <= result_i;
    end
  end

  assign result_o.valid          = valid_q;
  assign result_o.payload_byte   = data_q.payload_byte;
  assign result_o.last_byte      = data_q.last_byte;
  assign result_o.frame_error    = data_q.frame_error;
  assign result_o.mpeg_id        = data_q.mpeg_id;
  assign result_o.crc_absent     = data_q.crc_absent;
  assign result_o.profile        = data_q.profile;
  assign result_o.freq_index     = data_q.freq_index;
  assign result_o.sample_rate    = data_q.sample_rate;
  assign result_o.channel_config = data_q.channel_config;
  assign result_o.frame_length   = data_q.frame_length;

endmodule

// ----- src/adts_frame_splitter_core.sv -----
// Top level of the ADTS frame splitter: parser followed by a result register.
//
//  channel   | dir | beat                       | handshake
//  ----------+-----+----------------------------+------------------
//  stream_i  | in  | one ADTS stream byte       | valid / ready
//  result_o  | out | payload byte + header info | valid / ready
//
// One byte is taken every cycle while the result side keeps up; a byte that yields a beat
// loads the result register at the edge that accepts it, and the beat is offered next cycle.
// Header bytes and broken sync bytes give no beat; a short frame gives one error beat.
// Reset returns the parser to the sync hunt and empties the result register.
// While a held beat is not taken, stream_i.ready drops and nothing advances.
`timescale 1ns / 1ps
`include "adts_frame_splitter_core_macros.svh"
module adts_frame_splitter_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  adts_fs_in_if.sink    stream_i,
  adts_fs_out_if.source result_o
);
  import adts_fs_pkg::*;

  logic           accept;
  logic           can_load;
  logic           res_valid;
  result_t        result;
  parser_status_t status;

  assign stream_i.ready = can_load;
  assign accept         = stream_i.valid && can_load;

  adts_fs_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .byte_i      (stream_i.stream_byte),
    .res_valid_o (res_valid),
    .result_o    (result),
    .status_o    (status)
  );

  adts_fs_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (accept),
    .res_valid_i (res_valid),
    .result_i    (result),
    .can_load_o  (can_load),
    .result_o    (result_o)
  );

  `ADTS_FS_ASSERT_NEXT(a_payload_gives_beat, accept && status.phase == PH_PAYLOAD, result_o.valid)
  `ADTS_FS_ASSERT_SAME(a_stall_blocks_input, result_o.valid && !result_o.ready, !stream_i.ready)
  `ADTS_FS_ASSERT_NEXT(a_last_ends_frame, accept && res_valid && result.last_byte, status.phase == PH_HUNT)

endmodule

// ----- tb/tb.sv -----
// Self-checking testbench of the ADTS frame splitter: byte stream in, payload beats out.
`timescale 1ns / 1ps
module tb;
  import adts_fs_pkg::*;

  logic clk;
  logic rst_n;

  adts_fs_in_if  in_ch ();
  adts_fs_out_if out_ch ();

  adts_frame_splitter_core dut (
    .clk_i    (clk),
    .rst_ni   (rst_n),
    .stream_i (in_ch),
    .result_o (out_ch)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Sample rates in Hz by sampling frequency index; the last three are reserved.
  logic [16:0] hz_by_index [0:15] = '{
    17'd96000, 17'd88200, 17'd64000, 17'd48000, 17'd44100, 17'd32000, 17'd24000, 17'd22050,
    17'd16000, 17'd12000, 17'd11025, 17'd8000, 17'd7350, 17'd0, 17'd0, 17'd0
  };

  // Parser state as seen by the testbench.
  logic [1:0]  parse_phase;
  logic [2:0]  hdr_count;
  logic [55:0] hdr_bits;
  logic [12:0] bytes_left;

  result_t expected_beats [$];
  int      fail_count = 0;
  bit      idle_on = 1'b1;
  int      stall_left = 0;

  function automatic result_t beat_from_header(input logic [7:0] pay, input logic last,
                                               input logic err);
    result_t r;
    r.payload_byte   = pay;
    r.last_byte      = last;
    r.frame_error    = err;
    r.mpeg_id        = hdr_bits[43];
    r.crc_absent     = hdr_bits[40];
    r.profile        = hdr_bits[39:38];
    r.freq_index     = hdr_bits[37:34];
    r.sample_rate    = hz_by_index[hdr_bits[37:34]];
    r.channel_config = hdr_bits[32:30];
    r.frame_length   = hdr_bits[25:13];
    return r;
  endfunction

  // Advances the parser state by one byte; returns 1 when the byte yields a beat.
  function automatic bit parse_byte(input logic [7:0] b, output result_t r);
    logic [12:0] flen;
    bit          emits;
    emits = 1'b0;
    r = '0;
    case (parse_phase)
      PH_HUNT: begin
        if (b == SYNC_BYTE) begin
          hdr_bits = {48'd0, SYNC_BYTE};
          hdr_count = 3'd1;
          parse_phase = PH_SYNC2;
        end
      end
      PH_SYNC2: begin
        if (b[7:4] == SYNC_NIBBLE) begin
          hdr_bits = {hdr_bits[47:0], b};
          hdr_count = 3'd2;
          parse_phase = PH_HEADER;
        end else begin
          hdr_count = 3'd0;
          parse_phase = PH_HUNT;
        end
      end
      PH_HEADER: begin
        hdr_bits = {hdr_bits[47:0], b};
        hdr_count = hdr_count + 3'd1;
        if (hdr_count == HDR_LAST) begin
          hdr_count = 3'd0;
          flen = hdr_bits[25:13];
          if (flen <= HDR_BYTES) begin
            parse_phase = PH_HUNT;
            bytes_left = 13'd0;
            r = beat_from_header(8'h00, 1'b0, 1'b1);
            emits = 1'b1;
          end else begin
            bytes_left = flen - HDR_BYTES;
            parse_phase = PH_PAYLOAD;
          end
        end
      end
      default: begin
        emits = 1'b1;
        r = beat_from_header(b, bytes_left <= 13'd1, 1'b0);
        if (bytes_left <= 13'd1) begin
          bytes_left = 13'd0;
          parse_phase = PH_HUNT;
        end else begin
          bytes_left = bytes_left - 13'd1;
        end
      end
    endcase
    return emits;
  endfunction

  function automatic string beat_text(input result_t r);
    return $sformatf("pay=%h last=%b err=%b id=%b crc_abs=%b prof=%0d fi=%0d rate=%0d ch=%0d len=%0d",
                     r.payload_byte, r.last_byte, r.frame_error, r.mpeg_id, r.crc_absent,
                     r.profile, r.freq_index, r.sample_rate, r.channel_config, r.frame_length);
  endfunction

  function automatic void note_failure(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("%0t: %s", $realtime, msg);
  endfunction

  function automatic logic [55:0] build_header(input logic [43:0] filler, input logic id,
                                               input logic crc_abs, input logic [1:0] prof,
                                               input logic [3:0] fi, input logic [2:0] ch,
                                               input logic [12:0] flen);
    logic [55:0] h;
    h = {12'hFFF, filler};
    h[43] = id;
    h[40] = crc_abs;
    h[39:38] = prof;
    h[37:34] = fi;
    h[32:30] = ch;
    h[25:13] = flen;
    return h;
  endfunction

  // Receiver side: ready drops in random bursts while idling is on.
  always @(posedge clk) begin
    if (stall_left != 0) begin
      out_ch.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      out_ch.ready <= 1'b0;
      stall_left <= $urandom_range(0, 7);
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin : check_beats
    result_t got;
    result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.payload_byte   = out_ch.payload_byte;
      got.last_byte      = out_ch.last_byte;
      got.frame_error    = out_ch.frame_error;
      got.mpeg_id        = out_ch.mpeg_id;
      got.crc_absent     = out_ch.crc_absent;
      got.profile        = out_ch.profile;
      got.freq_index     = out_ch.freq_index;
      got.sample_rate    = out_ch.sample_rate;
      got.channel_config = out_ch.channel_config;
      got.frame_length   = out_ch.frame_length;
      if (expected_beats.size() == 0) begin
        note_failure({"unexpected beat: ", beat_text(got)});
      end else begin
        want = expected_beats.pop_front();
        if (got.payload_byte !== want.payload_byte || got.last_byte !== want.last_byte ||
            got.frame_error !== want.frame_error || got.mpeg_id !== want.mpeg_id ||
            got.crc_absent !== want.crc_absent || got.profile !== want.profile ||
            got.freq_index !== want.freq_index || got.sample_rate !== want.sample_rate ||
            got.channel_config !== want.channel_config ||
            got.frame_length !== want.frame_length)
          note_failure({"mismatch\n  expected ", beat_text(want), "\n  actual   ",
                        beat_text(got)});
      end
    end
  end

  // Offers one byte, optionally after an idle burst, and predicts once it is taken.
  task automatic send_byte(input logic [7:0] b);
    result_t r;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.stream_byte <= b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    if (parse_byte(b, r)) expected_beats.push_back(r);
  endtask

  task automatic send_header(input logic [55:0] h);
    for (int i = 6; i >= 0; i--) send_byte(h[i*8 +: 8]);
  endtask

  task automatic send_frame(input logic [55:0] h);
    send_header(h);
    if (h[25:13] > HDR_BYTES)
      for (int i = 0; i < h[25:13] - HDR_BYTES; i++) send_byte(8'($urandom_range(0, 255)));
  endtask

  task automatic wait_all_results();
    in_ch.valid <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed();
    // Broken sync: the byte after 0xFF lacks the 0xF high nibble.
    send_byte(SYNC_BYTE);
    send_byte(8'h0E);
    // Short frames of length zero and seven, with all fields at their extremes.
    send_frame(build_header({44{1'b1}}, 1'b1, 1'b1, 2'd3, 4'd15, 3'd7, 13'd0));
    send_frame(build_header(44'd0, 1'b0, 1'b0, 2'd0, 4'd0, 3'd0, 13'd7));
    // Shortest real frame: a single payload byte that is also the last.
    send_header(build_header(44'h5A5_A5A5_A5A5, 1'b1, 1'b0, 2'd1, 4'd12, 3'd2, 13'd8));
    send_byte(8'h00);
  endtask

  task automatic test_random_stream(input int n_items, input bit allow_idle);
    int          sent;
    logic [12:0] flen;
    logic [63:0] rnd;
    sent = 0;
    while (sent < n_items) begin
      idle_on = allow_idle && ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 5) == 0)
        repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 254)));
      if ($urandom_range(0, 9) == 0) begin
        send_byte(SYNC_BYTE);
        send_byte(8'($urandom_range(0, 8'hEF)));
      end
      case ($urandom_range(0, 15))
        0:       flen = 13'($urandom_range(0, 7));
        1:       flen = 13'($urandom_range(41, 300));
        default: flen = 13'($urandom_range(8, 40));
      endcase
      rnd = {$urandom, $urandom};
      send_frame(build_header(rnd[43:0], rnd[43], rnd[40], rnd[39:38], rnd[37:34],
                              rnd[32:30], flen));
      sent += (flen > HDR_BYTES) ? int'(flen) : int'(HDR_BYTES);
    end
  endtask

  task automatic test_long_frame();
    logic [63:0] rnd;
    rnd = {$urandom, $urandom};
    idle_on = 1'b1;
    send_frame(build_header(rnd[43:0], rnd[43], rnd[40], rnd[39:38], rnd[37:34],
                            rnd[32:30], 13'd700));
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.stream_byte = 8'h00;
    out_ch.ready = 1'b0;
    rst_n = 1'b0;
    parse_phase = PH_HUNT;
    hdr_count = 3'd0;
    hdr_bits = 56'd0;
    bytes_left = 13'd0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_random_stream(450, 1'b1);
    wait_all_results();
    test_random_stream(450, 1'b1);
    test_long_frame();
    test_random_stream(330, 1'b0);
    wait_all_results();
    repeat (20) @(posedge clk);

    if (expected_beats.size() != 0)
      note_failure($sformatf("%0d expected beats never arrived", expected_beats.size()));
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+src
src/adts_fs_pkg.sv
src/adts_fs_if.sv
src/adts_fs_parser.sv
src/adts_fs_out_reg.sv
src/adts_frame_splitter_core.sv
tb/tb.sv
